// ===== design/rcpa_pkg.sv =====
// rcpa_pkg: shared types and constants of the rc pulse capture and arm gesture unit
// no dependencies; used by rcpa_cfg_regs, rcpa_chan, rcpa_gesture and the top level
package rcpa_pkg;

  localparam int NUM_CH         = 4;
  localparam int WIDTH_W        = 16;
  localparam int ROUND_STEP     = 10;
  localparam int REM_W          = (ROUND_STEP > 1) ? $clog2(ROUND_STEP) : 1;
  localparam int STICK_RIGHT_US = 2000;
  localparam int STICK_LEFT_US  = 1000;
  localparam int STICK_DOWN_US  = 1000;
  localparam int ARM_HOLD_POLLS = 300;
  localparam int CNT_W          = 9;
  localparam int LOWER_RESET    = 1000;
  localparam int UPPER_RESET    = 2000;
  localparam int CH_YAW         = 0;
  localparam int CH_ALT         = 3;
  localparam int PADDR_W        = 5;
  localparam int PDATA_W        = 32;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_POLL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ARMED    = 2'd1,
    EV_DISARMED = 2'd2
  } arm_event_e;

  typedef struct packed {
    logic [WIDTH_W-1:0] lower;
    logic [WIDTH_W-1:0] upper;
  } bounds_t;

  typedef struct packed {
    logic tick;
    logic poll;
    logic chg;
  } chan_ctl_t;

endpackage

// ===== design/rcpa_in_if.sv =====
// rcpa_in_if: valid/ready channel carrying one input word
// depends on nothing
interface rcpa_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [3:0] pin_levels;

  modport source (output valid, output command, output pin_levels, input ready);
  modport sink (input valid, input command, input pin_levels, output ready);
endinterface

// ===== design/rcpa_out_if.sv =====
// rcpa_out_if: valid/ready channel carrying one result word
// depends on nothing
interface rcpa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] yaw_width;
  logic [15:0] pitch_width;
  logic [15:0] roll_width;
  logic [15:0] alt_width;
  logic [1:0]  arm_event;

  modport source (output valid, output yaw_width, output pitch_width, output roll_width,
                  output alt_width, output arm_event, input ready);
  modport sink (input valid, input yaw_width, input pitch_width, input roll_width,
                input alt_width, input arm_event, output ready);
endinterface

// ===== design/rcpa_cfg_regs.sv =====
// rcpa_cfg_regs: apb-style bound registers, lower and upper per channel
// depends on rcpa_pkg
module rcpa_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rcpa_pkg::PADDR_W-1:0]         paddr,
  input  logic [rcpa_pkg::PDATA_W-1:0]         pwdata,
  output logic [rcpa_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  output rcpa_pkg::bounds_t [rcpa_pkg::NUM_CH-1:0] bounds_o
);

  rcpa_pkg::bounds_t [rcpa_pkg::NUM_CH-1:0] bounds_q;
  logic                                     wr_en;
  logic [1:0]                               ch_sel;
  logic                                     upper_sel;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign ch_sel    = paddr[4:3];
  assign upper_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rcpa_pkg::NUM_CH; i++) begin
        bounds_q[i].lower <= rcpa_pkg::WIDTH_W'(rcpa_pkg::LOWER_RESET);
        bounds_q[i].upper <= rcpa_pkg::WIDTH_W'(rcpa_pkg::UPPER_RESET);
      end
    end else if (wr_en) begin
      if (upper_sel) begin
        bounds_q[ch_sel].upper <= pwdata[rcpa_pkg::WIDTH_W-1:0];
      end else begin
        bounds_q[ch_sel].lower <= pwdata[rcpa_pkg::WIDTH_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (upper_sel) begin
      prdata[rcpa_pkg::WIDTH_W-1:0] = bounds_q[ch_sel].upper;
    end else begin
      prdata[rcpa_pkg::WIDTH_W-1:0] = bounds_q[ch_sel].lower;
    end
  end

  assign bounds_o = bounds_q;

endmodule

// ===== design/rcpa_chan.sv =====
// rcpa_chan: one channel: tick counter kept in rounded form, capture, validation
// depends on rcpa_pkg
module rcpa_chan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rcpa_pkg::chan_ctl_t            ctl_i,
  input  rcpa_pkg::bounds_t              bounds_i,
  output logic [rcpa_pkg::WIDTH_W-1:0]   width_o
);

  logic [rcpa_pkg::WIDTH_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [rcpa_pkg::REM_W-1:0]   rem_q, rem_d, rem_inc;
  logic [rcpa_pkg::WIDTH_W-1:0] rnd_q, rnd_d, rnd_inc;
  logic [rcpa_pkg::WIDTH_W-1:0] capt_q, capt_d;
  logic [rcpa_pkg::WIDTH_W-1:0] held_q, held_d;
  logic [rcpa_pkg::WIDTH_W-1:0] valid_w;
  logic                         sat;

  assign sat = (elapsed_q == {rcpa_pkg::WIDTH_W{1'b1}});

  // rnd tracks elapsed rounded down to the step
  always_comb begin
    elapsed_inc = elapsed_q;
    rem_inc     = rem_q;
    rnd_inc     = rnd_q;
    if (!sat) begin
      elapsed_inc = elapsed_q + rcpa_pkg::WIDTH_W'(1);
      if (rem_q == rcpa_pkg::REM_W'(rcpa_pkg::ROUND_STEP - 1)) begin
        rem_inc = '0;
        rnd_inc = rnd_q + rcpa_pkg::WIDTH_W'(rcpa_pkg::ROUND_STEP);
      end else begin
        rem_inc = rem_q + rcpa_pkg::REM_W'(1);
      end
    end
  end

  assign valid_w = ((capt_q < bounds_i.lower) || (capt_q > bounds_i.upper)) ? held_q : capt_q;

  always_comb begin
    elapsed_d = elapsed_q;
    rem_d     = rem_q;
    rnd_d     = rnd_q;
    capt_d    = capt_q;
    held_d    = held_q;
    if (ctl_i.tick) begin
      if (ctl_i.chg) begin
        capt_d    = rnd_inc;
        elapsed_d = '0;
        rem_d     = '0;
        rnd_d     = '0;
      end else begin
        elapsed_d = elapsed_inc;
        rem_d     = rem_inc;
        rnd_d     = rnd_inc;
      end
    end else if (ctl_i.poll) begin
      capt_d = valid_w;
      held_d = valid_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      rem_q     <= '0;
      rnd_q     <= '0;
      capt_q    <= '0;
      held_q    <= '0;
    end else begin
      elapsed_q <= elapsed_d;
      rem_q     <= rem_d;
      rnd_q     <= rnd_d;
      capt_q    <= capt_d;
      held_q    <= held_d;
    end
  end

  assign width_o = valid_w;

endmodule

// ===== design/rcpa_gesture.sv =====
// rcpa_gesture: stick-hold counters and armed flag, gives the arm/disarm event
// depends on rcpa_pkg
module rcpa_gesture (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         poll_i,
  input  logic [rcpa_pkg::WIDTH_W-1:0] yaw_i,
  input  logic [rcpa_pkg::WIDTH_W-1:0] alt_i,
  output rcpa_pkg::arm_event_e         event_o
);

  logic [rcpa_pkg::CNT_W-1:0] arm_cnt_q, arm_cnt_d;
  logic [rcpa_pkg::CNT_W-1:0] dis_cnt_q, dis_cnt_d;
  logic                       armed_q, armed_d;
  logic                       hold_arm, hold_dis, alt_down;
  rcpa_pkg::arm_event_e       ev;

  assign alt_down = (alt_i == rcpa_pkg::WIDTH_W'(rcpa_pkg::STICK_DOWN_US));
  assign hold_arm = (yaw_i == rcpa_pkg::WIDTH_W'(rcpa_pkg::STICK_RIGHT_US)) && alt_down
                    && !armed_q;
  assign hold_dis = (yaw_i == rcpa_pkg::WIDTH_W'(rcpa_pkg::STICK_LEFT_US)) && alt_down
                    && armed_q;

  always_comb begin
    arm_cnt_d = arm_cnt_q;
    dis_cnt_d = dis_cnt_q;
    if (hold_arm) begin
      if (arm_cnt_q != {rcpa_pkg::CNT_W{1'b1}}) begin
        arm_cnt_d = arm_cnt_q + rcpa_pkg::CNT_W'(1);
      end
    end else if (hold_dis) begin
      if (dis_cnt_q != {rcpa_pkg::CNT_W{1'b1}}) begin
        dis_cnt_d = dis_cnt_q + rcpa_pkg::CNT_W'(1);
      end
    end else begin
      arm_cnt_d = '0;
      dis_cnt_d = '0;
    end
  end

  always_comb begin
    armed_d = armed_q;
    ev      = rcpa_pkg::EV_NONE;
    if ((arm_cnt_d == rcpa_pkg::CNT_W'(rcpa_pkg::ARM_HOLD_POLLS)) && !armed_q) begin
      armed_d = 1'b1;
      ev      = rcpa_pkg::EV_ARMED;
    end else if ((dis_cnt_d == rcpa_pkg::CNT_W'(rcpa_pkg::ARM_HOLD_POLLS)) && armed_q) begin
      armed_d = 1'b0;
      ev      = rcpa_pkg::EV_DISARMED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_cnt_q <= '0;
      dis_cnt_q <= '0;
      armed_q   <= 1'b0;
    end else if (poll_i) begin
      arm_cnt_q <= arm_cnt_d;
      dis_cnt_q <= dis_cnt_d;
      armed_q   <= armed_d;
    end
  end

  assign event_o = ev;

endmodule

// ===== design/rc_pulse_capture_arm_gesture_unit.sv =====
// rc_pulse_capture_arm_gesture_unit: top level, input register, channels, gesture, result register
// depends on rcpa_pkg, rcpa_in_if, rcpa_out_if, rcpa_cfg_regs, rcpa_chan, rcpa_gesture
//
//   channel   | dir | handshake          | word
//   item_i    | in  | valid/ready        | command, pin_levels
//   result_o  | out | valid/ready        | four widths, arm_event
//   apb       | in  | psel/penable/pready| bound registers at 4*index
//
// one word a cycle while no poll is stalled; a word in the input register executes when it fires
// a poll word lands in the result register at the edge where it executes; ticks give no result
// a poll waits in the input register only while the result register is full and stalled
// reset clears all counters, captures and held widths; bounds reset to 1000/2000
module rc_pulse_capture_arm_gesture_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rcpa_in_if.sink                      item_i,
  rcpa_out_if.source                   result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcpa_pkg::PADDR_W-1:0] paddr,
  input  logic [rcpa_pkg::PDATA_W-1:0] pwdata,
  output logic [rcpa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  rcpa_pkg::bounds_t [rcpa_pkg::NUM_CH-1:0] bounds;
  rcpa_pkg::chan_ctl_t [rcpa_pkg::NUM_CH-1:0] ctl;
  logic [rcpa_pkg::NUM_CH-1:0][rcpa_pkg::WIDTH_W-1:0] width;
  logic [rcpa_pkg::NUM_CH-1:0][rcpa_pkg::WIDTH_W-1:0] out_width_q;

  logic                        in_vld_q;
  rcpa_pkg::cmd_e              cmd_q;
  logic [rcpa_pkg::NUM_CH-1:0] lvl_q;
  logic [rcpa_pkg::NUM_CH-1:0] prev_q;
  logic [rcpa_pkg::NUM_CH-1:0] chg;
  logic                        fire, tick_fire, poll_fire;
  logic                        out_vld_q;
  logic [1:0]                  out_ev_q;
  rcpa_pkg::arm_event_e        ev;

  rcpa_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bounds_o (bounds)
  );

  assign fire      = in_vld_q && ((cmd_q == rcpa_pkg::CMD_TICK) || !out_vld_q || result_o.ready);
  assign tick_fire = fire && (cmd_q == rcpa_pkg::CMD_TICK);
  assign poll_fire = fire && (cmd_q == rcpa_pkg::CMD_POLL);
  assign chg       = lvl_q ^ prev_q;

  assign item_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      prev_q   <= '0;
    end else begin
      if (item_i.ready) begin
        in_vld_q <= item_i.valid;
      end
      if (tick_fire) begin
        prev_q <= lvl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      cmd_q <= rcpa_pkg::cmd_e'(item_i.command);
      lvl_q <= item_i.pin_levels;
    end
  end

  for (genvar g = 0; g < rcpa_pkg::NUM_CH; g++) begin : g_chan
    assign ctl[g].tick = tick_fire;
    assign ctl[g].poll = poll_fire;
    assign ctl[g].chg  = chg[g];

    rcpa_chan u_chan (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl[g]),
      .bounds_i (bounds[g]),
      .width_o  (width[g])
    );
  end

  rcpa_gesture u_gesture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .poll_i  (poll_fire),
    .yaw_i   (width[rcpa_pkg::CH_YAW]),
    .alt_i   (width[rcpa_pkg::CH_ALT]),
    .event_o (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (poll_fire) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_fire) begin
      out_width_q <= width;
      out_ev_q    <= 2'(ev);
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.yaw_width   = out_width_q[0];
  assign result_o.pitch_width = out_width_q[1];
  assign result_o.roll_width  = out_width_q[2];
  assign result_o.alt_width   = out_width_q[3];
  assign result_o.arm_event   = out_ev_q;

`ifndef SYNTHESIS
  a_poll_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_fire |=> out_vld_q)
    else $error("poll executed without loading a result");

  a_stalled_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !result_o.ready && !poll_fire) |=> (out_vld_q && $stable(out_width_q)))
    else $error("stalled result changed or dropped");

  a_no_poll_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (poll_fire && out_vld_q) |-> result_o.ready)
    else $error("poll overwrote an undelivered result");

  a_waiting_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(lvl_q) && $stable(cmd_q)))
    else $error("waiting input word lost");
`endif

endmodule
